/* rtl/core/tpss_pkg.sv */
// Shared constants, lookup tables and types for the probe sampling sequencer.
package tpss_pkg;

	localparam int TICKS_PER_PHASE = 10;
	localparam int WARMUP_CALCS    = 5;
	localparam int ROUNDS          = 10;

	localparam int TICK_W  = $clog2(TICKS_PER_PHASE + 1);
	localparam int RND_W   = $clog2(ROUNDS + 1);
	localparam int WARM_W  = (WARMUP_CALCS < 1) ? 1 : $clog2(WARMUP_CALCS + 1);

	localparam int SAMPLE_W = 12;
	localparam int SUM_W    = 16;
	localparam int PIN_W    = 8;
	localparam int CHAN_W   = 3;
	localparam int NUM_CH   = 4;

	localparam logic [TICK_W-1:0] TICK_DRIVE   = TICK_W'(1);
	localparam logic [TICK_W-1:0] TICK_CONVERT = TICK_W'(3);
	localparam logic [TICK_W-1:0] TICK_CAPTURE = TICK_W'(5);

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

	// indexed by phase
	localparam logic [CHAN_W-1:0] CHAN_OF_PHASE [NUM_CH] = '{3'd1, 3'd3, 3'd6, 3'd7};
	localparam logic [PIN_W-1:0]  START_CLR [NUM_CH] = '{8'h04, 8'h10, 8'h40, 8'h01};
	localparam logic [PIN_W-1:0]  START_SET [NUM_CH] = '{8'h08, 8'h20, 8'h80, 8'h02};
	localparam logic [PIN_W-1:0]  END_CLR   [NUM_CH] = '{8'h09, 8'h22, 8'h80, 8'h02};
	localparam logic [PIN_W-1:0]  END_SET   [NUM_CH] = '{8'h06, 8'h11, 8'h40, 8'h01};

	typedef struct packed {
		logic       cap;
		logic [1:0] ph;
		logic       first;
	} stat_ctl_t;

	typedef struct packed {
		logic [PIN_W-1:0]  pins;
		logic              start;
		logic [CHAN_W-1:0] chan;
		logic              full;
		logic              avg_valid;
	} seq_res_t;

	typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] avg_vec_t;

endpackage

/* rtl/core/tpss_seq.sv */
// Tick, phase, round and warm-up sequencing with excitation pin state.
module tpss_seq
	import tpss_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  logic      kind,
	output stat_ctl_t ctl,
	output seq_res_t  res
);

	logic [TICK_W-1:0] tick_q, tick_d, tick_inc;
	logic [1:0]        phase_q, phase_d;
	logic [RND_W-1:0]  round_q, round_d;
	logic [WARM_W-1:0] warm_q, warm_d;
	logic [PIN_W-1:0]  pins_q, pins_d;
	logic              full;

	assign full     = (round_q >= RND_W'(ROUNDS));
	assign tick_inc = tick_q + TICK_W'(1);

	always_comb begin
		tick_d        = tick_q;
		phase_d       = phase_q;
		round_d       = round_q;
		warm_d        = warm_q;
		pins_d        = pins_q;
		ctl.cap       = 1'b0;
		ctl.ph        = phase_q;
		ctl.first     = (round_q == '0);
		res.start     = 1'b0;
		res.chan      = '0;
		res.avg_valid = 1'b0;
		if (!kind) begin
			if (!full) begin
				tick_d = tick_inc;
				if (tick_inc == TICK_DRIVE) begin
					pins_d = (pins_q & ~START_CLR[phase_q]) | START_SET[phase_q];
				end else if (tick_inc == TICK_CONVERT) begin
					res.start = 1'b1;
					res.chan  = CHAN_OF_PHASE[phase_q];
				end else if (tick_inc == TICK_CAPTURE) begin
					ctl.cap = 1'b1;
				end else if (tick_inc >= TICK_W'(TICKS_PER_PHASE)) begin
					pins_d  = (pins_q & ~END_CLR[phase_q]) | END_SET[phase_q];
					tick_d  = '0;
					phase_d = phase_q + 2'd1;
					if (phase_q == 2'd3)
						round_d = round_q + RND_W'(1);
				end
			end
		end else if (full) begin
			if (warm_q < WARM_W'(WARMUP_CALCS)) begin
				warm_d = warm_q + WARM_W'(1);
			end else begin
				round_d       = '0;
				res.avg_valid = 1'b1;
			end
		end
		ctl.cap  = ctl.cap & fire;
		res.pins = pins_d;
		res.full = (round_d >= RND_W'(ROUNDS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			phase_q <= '0;
			round_q <= '0;
			warm_q  <= '0;
			pins_q  <= '0;
		end else if (fire) begin
			tick_q  <= tick_d;
			phase_q <= phase_d;
			round_q <= round_d;
			warm_q  <= warm_d;
			pins_q  <= pins_d;
		end
	end

endmodule

/* rtl/core/tpss_stats.sv */
// Per-channel running sum, minimum and maximum, and trimmed means.
module tpss_stats
	import tpss_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  stat_ctl_t           ctl,
	input  logic [SAMPLE_W-1:0] sample,
	output avg_vec_t            avg
);

	logic [SUM_W-1:0]    sum_q [NUM_CH];
	logic [SAMPLE_W-1:0] max_q [NUM_CH];
	logic [SAMPLE_W-1:0] min_q [NUM_CH];
	logic [SUM_W-1:0]    trim  [NUM_CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CH; c++) begin
				sum_q[c] <= '0;
				max_q[c] <= '0;
				min_q[c] <= SAMPLE_MAX;
			end
		end else if (ctl.cap) begin
			if (ctl.first) begin
				sum_q[ctl.ph] <= SUM_W'(sample);
				max_q[ctl.ph] <= sample;
				min_q[ctl.ph] <= sample;
			end else begin
				sum_q[ctl.ph] <= sum_q[ctl.ph] + SUM_W'(sample);
				if (sample > max_q[ctl.ph])
					max_q[ctl.ph] <= sample;
				if (sample < min_q[ctl.ph])
					min_q[ctl.ph] <= sample;
			end
		end
	end

	// low 16 bits of the difference are enough for bits [14:3]
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			trim[c] = sum_q[c] - SUM_W'(min_q[c]) - SUM_W'(max_q[c]);
			avg[c]  = trim[c][SAMPLE_W+2:3];
		end
	end

endmodule

/* rtl/core/tds_probe_sampling_sequencer.sv */
// Top level of the probe sampling sequencer: input stage, sequencing, result register.
//
//  channel | dir | tdata                      | tuser
//  s_*     | in  | adc_result [11:0]          | kind [0]
//  m_*     | out | pins, conv, chan, avgs     | -
//
// One transfer per cycle sustained while the receiver is ready; each item passes through
// the input register and then the result register.
// All state updates happen as an item leaves the input register.
// Reset clears all counters, pins and statistics (minimums to 4095).
// A stalled result holds; the input register keeps accepting while it is
// empty or the result register is empty or drains in the same cycle.
module tds_probe_sampling_sequencer
	import tpss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // adc_result[11:0], zero [15:12]
	input  logic [0:0]  s_tuser,  // kind[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // pin_levels[7:0], start_conversion[8], adc_channel[11:9],
	                              // collection_full[12], averages_valid[13], avg_pure[25:14],
	                              // avg_waste[37:26], avg_leak[49:38], avg_raw[61:50], zero[63:62]
);

	logic                v_s1;
	logic                kind_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                v_s2;
	seq_res_t            res_s2;
	avg_vec_t            avg_s2;

	logic      out_free, fire;
	stat_ctl_t ctl;
	seq_res_t  res;
	avg_vec_t  avg;

	assign out_free = !v_s2 || m_tready;
	assign fire     = v_s1 && out_free;
	assign s_tready = !v_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1   <= s_tuser[0];
			sample_s1 <= s_tdata[SAMPLE_W-1:0];
		end
	end

	tpss_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.kind   (kind_s1),
		.ctl    (ctl),
		.res    (res)
	);

	tpss_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (sample_s1),
		.avg    (avg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (out_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
			avg_s2 <= res.avg_valid ? avg : '0;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = {2'b00, avg_s2[3], avg_s2[2], avg_s2[1], avg_s2[0],
	                   res_s2.avg_valid, res_s2.full, res_s2.chan, res_s2.start, res_s2.pins};

	a_avg_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && res_s2.avg_valid |-> !res_s2.full)
		else $error("averages reported with collection still full");

	a_chan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !res_s2.start |-> res_s2.chan == '0)
		else $error("channel set without conversion start");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !out_free |=> v_s1 && $stable(kind_s1) && $stable(sample_s1))
		else $error("input stage item lost while result stalled");

	a_cap_collect: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cap |-> fire && !kind_s1)
		else $error("capture outside an advancing collection tick");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Stream-level testbench for the probe sampling sequencer with a scoreboard class.
module tb;

	localparam bit KIND_COLLECT = 1'b0;
	localparam bit KIND_CALC    = 1'b1;

	localparam int PHASE_TICKS  = 10;
	localparam int WARMUP_TICKS = 5;
	localparam int FULL_ROUNDS  = 10;
	localparam int TICK_DRIVE   = 1;
	localparam int TICK_CONVERT = 3;
	localparam int TICK_CAPTURE = 5;

	localparam bit [11:0] PHASE_CHAN = {3'd7, 3'd6, 3'd3, 3'd1};

	localparam int ITEMS_PER_STAGE = 500;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 10;
	localparam int CYCLE_LIMIT     = 200000;

	class probe_scoreboard;
		bit [3:0]  tick_n;
		bit [1:0]  phase_n;
		bit [3:0]  round_n;
		bit [3:0]  warm_n;
		bit [7:0]  pins;
		bit [15:0] ch_sum [4];
		bit [11:0] ch_max [4];
		bit [11:0] ch_min [4];
		bit [63:0] expected_q [$];
		int        mismatches;

		function new();
			for (int c = 0; c < 4; c++) begin
				ch_sum[c] = '0;
				ch_max[c] = '0;
				ch_min[c] = 12'hfff;
			end
			tick_n     = '0;
			phase_n    = '0;
			round_n    = '0;
			warm_n     = '0;
			pins       = '0;
			mismatches = 0;
		endfunction

		function bit full();
			return round_n >= FULL_ROUNDS;
		endfunction

		function void drive_pins(bit [7:0] clr, bit [7:0] set_bits);
			pins = (pins & ~clr) | set_bits;
		endfunction

		function void note_input(bit kind, bit [11:0] sample);
			bit        start;
			bit [2:0]  chan;
			bit        valid;
			bit [11:0] avg [4];
			bit [31:0] span;
			start = 1'b0;
			chan  = '0;
			valid = 1'b0;
			for (int c = 0; c < 4; c++)
				avg[c] = '0;
			if (kind == KIND_COLLECT) begin
				if (!full()) begin
					tick_n++;
					if (tick_n == TICK_DRIVE) begin
						case (phase_n)
							2'd0: drive_pins(8'h04, 8'h08);
							2'd1: drive_pins(8'h10, 8'h20);
							2'd2: drive_pins(8'h40, 8'h80);
							default: drive_pins(8'h01, 8'h02);
						endcase
					end else if (tick_n == TICK_CONVERT) begin
						start = 1'b1;
						chan  = PHASE_CHAN[phase_n*3 +: 3];
					end else if (tick_n == TICK_CAPTURE) begin
						if (round_n == 0) begin
							ch_sum[phase_n] = 16'(sample);
							ch_max[phase_n] = sample;
							ch_min[phase_n] = sample;
						end else begin
							ch_sum[phase_n] = ch_sum[phase_n] + 16'(sample);
							if (sample > ch_max[phase_n])
								ch_max[phase_n] = sample;
							if (sample < ch_min[phase_n])
								ch_min[phase_n] = sample;
						end
					end else if (tick_n >= PHASE_TICKS) begin
						case (phase_n)
							2'd0: drive_pins(8'h09, 8'h06);
							2'd1: drive_pins(8'h22, 8'h11);
							2'd2: drive_pins(8'h80, 8'h40);
							default: drive_pins(8'h02, 8'h01);
						endcase
						tick_n = '0;
						if (phase_n == 2'd3)
							round_n++;
						phase_n++;
					end
				end
			end else if (full()) begin
				if (warm_n < WARMUP_TICKS) begin
					warm_n++;
				end else begin
					round_n = '0;
					valid   = 1'b1;
					for (int c = 0; c < 4; c++) begin
						span   = 32'(ch_sum[c]) - 32'(ch_min[c]) - 32'(ch_max[c]);
						avg[c] = span[14:3];
					end
				end
			end
			expected_q.push_back({2'b00, avg[3], avg[2], avg[1], avg[0], valid, full(),
				chan, start, pins});
		endfunction

		function void check_result(bit [63:0] got);
			int        lsb [10] = '{0, 8, 9, 12, 13, 14, 26, 38, 50, 62};
			int        wid [10] = '{8, 1, 3, 1, 1, 12, 12, 12, 12, 2};
			string     names [10] = '{"pin_levels", "start_conversion", "adc_channel",
				"collection_full", "averages_valid", "avg_pure", "avg_waste", "avg_leak",
				"avg_raw", "padding"};
			bit [63:0] want;
			bit [63:0] mask;
			bit [63:0] e;
			bit [63:0] a;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer %h", got);
				return;
			end
			want = expected_q.pop_front();
			for (int f = 0; f < 10; f++) begin
				mask = (64'd1 << wid[f]) - 64'd1;
				e = (want >> lsb[f]) & mask;
				a = (got >> lsb[f]) & mask;
				if (e != a) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch %s: expected %0h, got %0h", names[f], e, a);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;

	int tx_idle;
	int rx_idle;
	bit hold_req;
	int cycles = 0;

	probe_scoreboard sb = new();

	tds_probe_sampling_sequencer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tds_probe_sampling_sequencer verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// receiver: random backpressure, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// entered and left at a falling edge
	task automatic send_item(input bit kind, input bit [11:0] sample);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, sample};
		s_tuser  <= kind;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_input(kind, sample);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		bit        kind;
		bit        was_full;
		bit [11:0] sample;
		bit [11:0] pattern [4];
		int        set_mode;
		int        r;
		pattern  = '{12'hfff, 12'h000, 12'haaa, 12'h555};
		set_mode = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		tx_idle  = 0;
		rx_idle  = 0;
		hold_req = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// calc ticks on an empty set are ignored and do not count as warm-up
		send_item(KIND_CALC, 12'hfff);
		send_item(KIND_CALC, 12'h000);
		for (int i = 0; i < 20; i++)
			send_item(KIND_COLLECT, pattern[i % 4]);
		wait_drained();

		for (int stage = 0; stage < 3; stage++) begin
			tx_idle = (stage == 0) ? 11 : (stage == 1) ? 74 : 0;
			rx_idle = (stage == 0) ? 74 : (stage == 1) ? 11 : 0;
			for (int i = 0; i < ITEMS_PER_STAGE; i++) begin
				if (stage == 2 && i == 100)
					hold_req = 1'b1;
				was_full = sb.full();
				if (was_full)
					kind = 1'($urandom_range(1));
				else
					kind = ($urandom_range(49) == 0);
				case (set_mode)
					1: sample = 12'hfff;
					2: sample = 12'h000;
					default: begin
						r = $urandom_range(7);
						sample = (r == 0) ? 12'h000 : (r == 1) ? 12'hfff :
							12'($urandom_range(4095));
					end
				endcase
				send_item(kind, sample);
				if (was_full && !sb.full())
					set_mode = $urandom_range(3);
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("tds_probe_sampling_sequencer verification clean");
		else
			$display("tds_probe_sampling_sequencer verification failed");
		$finish;
	end

endmodule
